// ===== rtl/dining_seat_arbiter_top_defines.svh =====
// Assertion macros shared by the dining seat arbiter RTL.
`ifndef DINING_SEAT_ARBITER_TOP_DEFINES_SVH
`define DINING_SEAT_ARBITER_TOP_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define DSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
    `DSA_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/dsa_pkg.sv =====
// Package with shared types and constants of the dining seat arbiter.
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int unsigned MAX_SEATS_DEF  = 16;
    localparam int unsigned MEAL_WIDTH_DEF = 32;
    localparam int unsigned RESET_SEATS    = 5;
    localparam int unsigned COIN_WIDTH     = 16;
    localparam int unsigned QUERY_WIDTH    = 4;
    localparam int unsigned CFG_WIDTH      = 5;
    localparam int unsigned SHOWN_LIMIT    = 16;
    localparam int unsigned MIN_SEATS      = 2;

    typedef enum logic [1:0] {
        THINKING = 2'd0,
        HUNGRY   = 2'd1,
        EATING   = 2'd2
    } seat_state_t;

endpackage

// ===== rtl/dsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dsa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dining_seat_arbiter_top.sv =====
// An accepted item passes through S_RD, an S_UPD step for each seat, S_QRD and S_QOUT.
// A new item is taken only in S_IDLE. Seats are visited one per cycle; each reads its
// meal count via the single meal RAM port pair, writing it back when it stops eating.
// A result waiting on a stalled output does not block the next input transfer.
// Reset and a seat count write set all seats thinking and all meal counts to zero.
`timescale 1ns / 1ps
`include "dining_seat_arbiter_top_defines.svh"

module dining_seat_arbiter_top
    import dsa_pkg::*;
#(
    parameter int unsigned MAX_SEATS  = MAX_SEATS_DEF,
    parameter int unsigned MEAL_WIDTH = MEAL_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_WIDTH-1:0]   num_seats,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COIN_WIDTH-1:0]  coin_bits,
    input  logic [QUERY_WIDTH-1:0] query_seat,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            seat_states,
    output logic [3:0]             seats_eating,
    output logic [31:0]            queried_meals
);

    localparam int unsigned SEAT_W  = $clog2(MAX_SEATS);
    localparam int unsigned CNT_W   = $clog2(MAX_SEATS + 1);
    localparam int unsigned SHOWN   = (MAX_SEATS < SHOWN_LIMIT) ? MAX_SEATS : SHOWN_LIMIT;
    localparam int unsigned RESET_N = (RESET_SEATS > MAX_SEATS) ? MAX_SEATS : RESET_SEATS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_QRD,
        S_QOUT
    } state_t;

    state_t                  state_reg;
    seat_state_t             ring_reg [MAX_SEATS];
    seat_state_t             ring_next [MAX_SEATS];
    seat_state_t             left_reg;
    seat_state_t             cur_next;
    logic [MAX_SEATS-1:0]    valid_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        eat_reg;
    logic [CNT_W-1:0]        eat_next;
    logic [SEAT_W-1:0]       k_reg;
    logic [COIN_WIDTH-1:0]   coin_reg;
    logic [QUERY_WIDTH-1:0]  query_reg;
    logic                    hit_reg;
    logic                    last_seat;
    logic                    query_in_range;
    logic [SEAT_W-1:0]       query_addr;
    logic [5:0]              cfg_seats;
    logic [CNT_W-1:0]        cfg_n;

    logic                    ram_we;
    logic [SEAT_W-1:0]       ram_raddr;
    logic [MEAL_WIDTH-1:0]   ram_rdata;
    logic [MEAL_WIDTH-1:0]   meal_cur;
    logic [MEAL_WIDTH-1:0]   meal_inc;
    logic [MEAL_WIDTH+31:0]  meal_wide;
    logic [31:0]             meals_next;
    logic [31:0]             states_next;
    logic [3:0]              eating_next;

    logic                    out_valid_reg;
    logic [31:0]             seat_states_reg;
    logic [3:0]              seats_eating_reg;
    logic [31:0]             queried_meals_reg;

    dsa_ram #(
        .WIDTH (MEAL_WIDTH),
        .DEPTH (MAX_SEATS)
    ) u_meal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (meal_inc),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);

    assign last_seat      = (CNT_W'(k_reg) == n_reg - CNT_W'(1));
    assign query_in_range = ((CNT_W + QUERY_WIDTH)'(query_reg) < (CNT_W + QUERY_WIDTH)'(n_reg));
    assign query_addr     = SEAT_W'(query_reg);

    always_comb
    begin
        cfg_seats = {1'b0, num_seats};
        if (cfg_seats < 6'(MIN_SEATS))
        begin
            cfg_seats = 6'(MIN_SEATS);
        end
        else if (cfg_seats > 6'(MAX_SEATS))
        begin
            cfg_seats = 6'(MAX_SEATS);
        end
        cfg_n = CNT_W'(cfg_seats);
    end

    always_comb
    begin
        case (state_reg)
            S_UPD:   ram_raddr = k_reg + SEAT_W'(1);
            S_QRD:   ram_raddr = query_addr;
            S_QOUT:  ram_raddr = query_addr;
            default: ram_raddr = k_reg;
        endcase
    end

    // Seat update for the seat at the head of the ring.
    always_comb
    begin
        meal_cur = valid_reg[k_reg] ? ram_rdata : '0;
        meal_inc = (meal_cur == '1) ? meal_cur : meal_cur + MEAL_WIDTH'(1);
        cur_next = ring_reg[0];
        eat_next = eat_reg;
        ram_we   = 1'b0;
        case (ring_reg[0])
            THINKING:
            begin
                if (coin_reg[0])
                begin
                    cur_next = HUNGRY;
                end
            end
            HUNGRY:
            begin
                if ((eat_reg < n_reg - CNT_W'(1)) && (left_reg != EATING)
                    && (ring_reg[1] != EATING))
                begin
                    cur_next = EATING;
                    eat_next = eat_reg + CNT_W'(1);
                end
            end
            EATING:
            begin
                if (coin_reg[0])
                begin
                    cur_next = THINKING;
                    eat_next = (eat_reg != '0) ? eat_reg - CNT_W'(1) : eat_reg;
                    ram_we   = (state_reg == S_UPD);
                end
            end
            default:
            begin
                cur_next = ring_reg[0];
            end
        endcase
    end

    // The ring rotates by one seat per step, so the current seat is always at the head.
    always_comb
    begin
        for (int i = 0; i < MAX_SEATS; i++)
        begin
            ring_next[i] = ring_reg[i];
        end
        for (int i = 0; i < MAX_SEATS - 1; i++)
        begin
            if (i < int'(n_reg) - 1)
            begin
                ring_next[i] = ring_reg[i + 1];
            end
        end
        for (int i = 0; i < MAX_SEATS; i++)
        begin
            if (i == int'(n_reg) - 1)
            begin
                ring_next[i] = cur_next;
            end
        end
    end

    always_comb
    begin
        states_next = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            states_next[2*i +: 2] = ring_reg[i];
        end
        eating_next = (32'(eat_reg) > 32'd15) ? 4'd15 : 4'(eat_reg);
        meal_wide   = hit_reg ? (MEAL_WIDTH + 32)'(ram_rdata) : '0;
        if (meal_wide > (MEAL_WIDTH + 32)'(32'hFFFF_FFFF))
        begin
            meals_next = 32'hFFFF_FFFF;
        end
        else
        begin
            meals_next = meal_wide[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= CNT_W'(RESET_N);
            eat_reg       <= '0;
            left_reg      <= THINKING;
            valid_reg     <= '0;
            k_reg         <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SEATS; i++)
            begin
                ring_reg[i] <= THINKING;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_QOUT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                n_reg     <= cfg_n;
                eat_reg   <= '0;
                left_reg  <= THINKING;
                valid_reg <= '0;
                for (int i = 0; i < MAX_SEATS; i++)
                begin
                    ring_reg[i] <= THINKING;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        coin_reg  <= coin_bits;
                        query_reg <= query_seat;
                        k_reg     <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    ring_reg <= ring_next;
                    left_reg <= cur_next;
                    eat_reg  <= eat_next;
                    coin_reg <= coin_reg >> 1;
                    if (ram_we)
                    begin
                        valid_reg[k_reg] <= 1'b1;
                    end
                    if (last_seat)
                    begin
                        state_reg <= S_QRD;
                    end
                    else
                    begin
                        k_reg <= k_reg + SEAT_W'(1);
                    end
                end
                S_QRD:
                begin
                    hit_reg   <= query_in_range && valid_reg[query_addr];
                    state_reg <= S_QOUT;
                end
                S_QOUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg     <= 1'b1;
                        seat_states_reg   <= states_next;
                        seats_eating_reg  <= eating_next;
                        queried_meals_reg <= meals_next;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign seat_states   = seat_states_reg;
    assign seats_eating  = seats_eating_reg;
    assign queried_meals = queried_meals_reg;

    `DSA_ASSERT(a_eat_bound, eat_reg < n_reg, "Eating count reached the seat count.")
    `DSA_ASSERT(a_meal_write,
        !ram_we || (state_reg == S_UPD && ring_reg[0] == EATING),
        "Meal write outside an eating seat update.")
    `DSA_ASSERT_NEXT(a_result_load,
        (state_reg == S_QOUT) && !(out_valid_reg && out_stall),
        out_valid_reg && (state_reg == S_IDLE),
        "Result was not loaded.")

endmodule
